@@ rtl/core/xxh64_stream_hash_core_assert.svh @@
// Assertion macros for the xxh64 stream hash core.
// Included by the top level; relies on nothing else.
`ifndef XXH64_STREAM_HASH_CORE_ASSERT_SVH
`define XXH64_STREAM_HASH_CORE_ASSERT_SVH

// same-cycle implication
`define XXH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define XXH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/xxh_pkg.sv @@
// Shared constants, types and helpers for the xxh64 stream hash core.
// No dependencies.
package xxh_pkg;

  localparam logic [63:0] PR1 = 64'h9E3779B185EBCA87;
  localparam logic [63:0] PR2 = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] PR3 = 64'h165667B19E3779F9;
  localparam logic [63:0] PR4 = 64'h85EBCA77C2B2AE63;
  localparam logic [63:0] PR5 = 64'h27D4EB2F165667C5;

  localparam int LEN_BITS_DEF = 64;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] p;
  } mul_resp_t;

  function automatic logic [63:0] rotl(input logic [63:0] v, input int n);
    rotl = (v << n) | (v >> (64 - n));
  endfunction

endpackage

@@ rtl/core/xxh_mul.sv @@
// Iterative 64x64 multiplier, low 64 bits of the product.
// One 32x32 multiplier is reused for three partial products; uses xxh_pkg.
module xxh_mul (
  input  logic              clk,
  input  logic              rst,
  input  xxh_pkg::mul_req_t req,
  output xxh_pkg::mul_resp_t resp
);
  import xxh_pkg::*;

  logic [2:0]  step;
  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [63:0] prod;
  logic [63:0] acc;
  logic [31:0] ma;
  logic [31:0] mb;
  logic [63:0] mp;

  always_comb begin
    unique case (step)
      3'd2: begin
        ma = a_r[31:0];
        mb = b_r[63:32];
      end
      3'd3: begin
        ma = a_r[63:32];
        mb = b_r[31:0];
      end
      default: begin
        ma = a_r[31:0];
        mb = b_r[31:0];
      end
    endcase
  end

  // both operands are 32 bits wide; the upper halves are zero
  assign mp = 64'(ma) * 64'(mb);

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= 3'd0;
    end else if (req.start) begin
      step <= 3'd1;
    end else if (step != 3'd0) begin
      step <= (step == 3'd4) ? 3'd0 : step + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r <= req.a;
      b_r <= req.b;
    end
    unique case (step)
      3'd1: prod <= mp;
      3'd2: begin
        acc  <= prod;
        prod <= mp;
      end
      3'd3: begin
        acc  <= acc + {prod[31:0], 32'h0};
        prod <= mp;
      end
      default: ;
    endcase
  end

  // cross terms only reach the upper half
  assign resp.done = (step == 3'd4);
  assign resp.p    = acc + {prod[31:0], 32'h0};

endmodule

@@ rtl/core/xxh64_stream_hash_core.sv @@
// Top level of the streaming xxh64 hash: sequencer, lane/state registers, output register.
// Uses xxh_pkg, xxh_mul and xxh64_stream_hash_core_assert.svh.
//
// channel  | handshake              | payload
// in       | in_valid / in_stall    | data_word, byte_count, last_item
// out      | out_valid / out_stall  | hash_value
// cfg      | cfg_valid / cfg_ready  | seed
//
// A word that fills pending storage is stored in a pending register; a word that completes a stripe
// runs 8 multiplies on the shared multiplier while in_stall is high.
// The last item adds finalization: after a stripe, the lane merge and the fold of each lane;
// then the length, each pending word, a 4-byte piece, each tail byte, the avalanche
// and the output register.
// Reset (rst, synchronous) clears control state; lanes load from seed on first stripe.
// The result sits in an output register, so out_stall only holds the next message's end.
module xxh64_stream_hash_core #(
  parameter int LENGTH_BITS = xxh_pkg::LEN_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] data_word,
  input  logic [3:0]  byte_count,
  input  logic        last_item,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] hash_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] seed
);
  import xxh_pkg::*;

  `include "xxh64_stream_hash_core_assert.svh"

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_LANE1  = 5'd1;
  localparam logic [4:0] S_LANE2  = 5'd2;
  localparam logic [4:0] S_MERGE  = 5'd3;
  localparam logic [4:0] S_FOLD1  = 5'd4;
  localparam logic [4:0] S_FOLD2  = 5'd5;
  localparam logic [4:0] S_FOLD3  = 5'd6;
  localparam logic [4:0] S_SHORT  = 5'd7;
  localparam logic [4:0] S_ADDLEN = 5'd8;
  localparam logic [4:0] S_PEND1  = 5'd9;
  localparam logic [4:0] S_PEND2  = 5'd10;
  localparam logic [4:0] S_PEND3  = 5'd11;
  localparam logic [4:0] S_TAIL4A = 5'd12;
  localparam logic [4:0] S_TAIL4B = 5'd13;
  localparam logic [4:0] S_BYTE1  = 5'd14;
  localparam logic [4:0] S_BYTE2  = 5'd15;
  localparam logic [4:0] S_AVAL1  = 5'd16;
  localparam logic [4:0] S_AVAL2  = 5'd17;
  localparam logic [4:0] S_OUT    = 5'd18;

  logic [4:0]  state;
  logic        issued;
  logic [63:0] hash_seed;
  logic [63:0] lane_acc [4];
  logic [63:0] pending_words [3];
  logic [1:0]  pending_count;
  logic [LENGTH_BITS-1:0] total_length;
  logic        stripe_seen;
  logic [1:0]  idx;
  logic        last_q;
  logic [63:0] tail_word;
  logic [2:0]  tail_n;
  logic [63:0] h;
  logic [63:0] t;

  logic        accept;
  logic [3:0]  eff_count;
  logic        full_word;
  logic        is_mul;
  logic [4:0]  fin_entry;
  logic [4:0]  tail_entry;
  logic [63:0] lane_sel;
  logic [63:0] pend_sel;
  logic [63:0] merge_rot;
  logic [2:0]  idx_inc;
  mul_req_t    mreq;
  mul_resp_t   mresp;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign eff_count = (!last_item || byte_count > 4'd8) ? 4'd8 : byte_count;
  assign full_word = (eff_count == 4'd8);
  assign lane_sel  = lane_acc[idx];
  assign pend_sel  = (idx == 2'd3) ? tail_word : pending_words[idx];
  assign idx_inc   = {1'b0, idx} + 3'd1;
  assign fin_entry = stripe_seen ? S_MERGE : S_SHORT;
  assign tail_entry = (tail_n >= 3'd4) ? S_TAIL4A :
                      (tail_n != 3'd0) ? S_BYTE1 : S_AVAL1;

  always_comb begin
    unique case (idx)
      2'd0: merge_rot = rotl(lane_sel, 1);
      2'd1: merge_rot = rotl(lane_sel, 7);
      2'd2: merge_rot = rotl(lane_sel, 12);
      default: merge_rot = rotl(lane_sel, 18);
    endcase
  end

  always_comb begin
    is_mul = 1'b1;
    mreq.a = h;
    mreq.b = PR1;
    unique case (state)
      S_LANE1: begin
        mreq.a = pend_sel;
        mreq.b = PR2;
      end
      S_FOLD1: begin
        mreq.a = lane_sel;
        mreq.b = PR2;
      end
      S_PEND1: begin
        mreq.a = pending_words[idx];
        mreq.b = PR2;
      end
      S_LANE2, S_FOLD2, S_PEND2: mreq.a = rotl(t, 31);
      S_FOLD3: mreq.a = h;
      S_PEND3: mreq.a = rotl(h, 27);
      S_TAIL4A: mreq.a = {32'h0, tail_word[31:0]};
      S_TAIL4B: begin
        mreq.a = rotl(h, 23);
        mreq.b = PR2;
      end
      S_BYTE1: begin
        mreq.a = {56'h0, tail_word[7:0]};
        mreq.b = PR5;
      end
      S_BYTE2: mreq.a = rotl(h, 11);
      S_AVAL1: begin
        mreq.a = h ^ (h >> 33);
        mreq.b = PR2;
      end
      S_AVAL2: begin
        mreq.a = h ^ (h >> 29);
        mreq.b = PR3;
      end
      default: is_mul = 1'b0;
    endcase
    mreq.start = is_mul && !issued;
  end

  xxh_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .resp (mresp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      issued        <= 1'b0;
      hash_seed     <= 64'h0;
      pending_count <= 2'd0;
      total_length  <= '0;
      stripe_seen   <= 1'b0;
      idx           <= 2'd0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        hash_seed <= seed;
      end
      // the output state reloads the register itself
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      if (mreq.start) begin
        issued <= 1'b1;
      end else if (mresp.done) begin
        issued <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            total_length <= total_length + LENGTH_BITS'(eff_count);
            last_q       <= last_item;
            tail_word    <= data_word;
            tail_n       <= full_word ? 3'd0 : eff_count[2:0];
            if (full_word && pending_count == 2'd3) begin
              if (!stripe_seen) begin
                lane_acc[0] <= hash_seed + PR1 + PR2;
                lane_acc[1] <= hash_seed + PR2;
                lane_acc[2] <= hash_seed;
                lane_acc[3] <= hash_seed - PR1;
                stripe_seen <= 1'b1;
              end
              state <= S_LANE1;
            end else begin
              if (full_word) begin
                pending_words[pending_count] <= data_word;
                pending_count <= pending_count + 2'd1;
              end
              if (last_item) begin
                state <= fin_entry;
              end
            end
          end
        end
        S_LANE1: if (mresp.done) begin
          t     <= lane_sel + mresp.p;
          state <= S_LANE2;
        end
        S_LANE2: if (mresp.done) begin
          lane_acc[idx] <= mresp.p;
          idx <= idx + 2'd1;
          if (idx == 2'd3) begin
            pending_count <= 2'd0;
            state <= last_q ? S_MERGE : S_IDLE;
          end else begin
            state <= S_LANE1;
          end
        end
        S_MERGE: begin
          h   <= ((idx == 2'd0) ? 64'h0 : h) + merge_rot;
          idx <= idx + 2'd1;
          if (idx == 2'd3) state <= S_FOLD1;
        end
        S_FOLD1: if (mresp.done) begin
          t     <= mresp.p;
          state <= S_FOLD2;
        end
        S_FOLD2: if (mresp.done) begin
          h     <= h ^ mresp.p;
          state <= S_FOLD3;
        end
        S_FOLD3: if (mresp.done) begin
          h   <= mresp.p + PR4;
          idx <= idx + 2'd1;
          state <= (idx == 2'd3) ? S_ADDLEN : S_FOLD1;
        end
        S_SHORT: begin
          h     <= hash_seed + PR5;
          state <= S_ADDLEN;
        end
        S_ADDLEN: begin
          h     <= h + 64'(total_length);
          state <= (pending_count != 2'd0) ? S_PEND1 : tail_entry;
        end
        S_PEND1: if (mresp.done) begin
          t     <= mresp.p;
          state <= S_PEND2;
        end
        S_PEND2: if (mresp.done) begin
          h     <= h ^ mresp.p;
          state <= S_PEND3;
        end
        S_PEND3: if (mresp.done) begin
          h <= mresp.p + PR4;
          if (idx_inc < {1'b0, pending_count}) begin
            idx   <= idx + 2'd1;
            state <= S_PEND1;
          end else begin
            idx   <= 2'd0;
            state <= tail_entry;
          end
        end
        S_TAIL4A: if (mresp.done) begin
          h     <= h ^ mresp.p;
          state <= S_TAIL4B;
        end
        S_TAIL4B: if (mresp.done) begin
          h         <= mresp.p + PR3;
          tail_word <= tail_word >> 32;
          tail_n    <= tail_n - 3'd4;
          state     <= (tail_n != 3'd4) ? S_BYTE1 : S_AVAL1;
        end
        S_BYTE1: if (mresp.done) begin
          h     <= h ^ mresp.p;
          state <= S_BYTE2;
        end
        S_BYTE2: if (mresp.done) begin
          h         <= mresp.p;
          tail_word <= tail_word >> 8;
          tail_n    <= tail_n - 3'd1;
          state     <= (tail_n != 3'd1) ? S_BYTE1 : S_AVAL1;
        end
        S_AVAL1: if (mresp.done) begin
          h     <= mresp.p;
          state <= S_AVAL2;
        end
        S_AVAL2: if (mresp.done) begin
          h     <= mresp.p;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            hash_value    <= h ^ (h >> 32);
            pending_count <= 2'd0;
            total_length  <= '0;
            stripe_seen   <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `XXH_ASSERT_NOW(a_done_issued, clk, rst, mresp.done, issued,
    "multiplier finished with no request outstanding")
  `XXH_ASSERT_NOW(a_merge_stripe, clk, rst, (state == S_MERGE) || (state == S_FOLD1),
    stripe_seen, "lane merge without a completed stripe")
  `XXH_ASSERT_NEXT(a_out_from_final, clk, rst, state != S_OUT,
    !$rose(out_valid), "result raised outside the output state")

endmodule
